// ----- rtl/ccw_pkg.sv -----
// Shared types, code constants and interval tables for the code point column width block.
`timescale 1ns / 1ps

package ccw_pkg;

	localparam int CP_W     = 21;
	localparam int COLS_W   = 3;
	localparam int IN_BYTES_W  = 24;
	localparam int OUT_BYTES_W = 8;
	localparam int ZW_COUNT   = 142;
	localparam int WIDE_COUNT = 12;

	typedef logic [CP_W-1:0]          cp_t;
	typedef logic signed [COLS_W-1:0] cols_t;

	typedef struct packed {
		cp_t lo;
		cp_t hi;
	} span_t;

	localparam cols_t COLS_ZERO = 3'sd0;
	localparam cols_t COLS_ONE  = 3'sd1;
	localparam cols_t COLS_TWO  = 3'sd2;
	localparam cols_t COLS_CTRL = -3'sd1;

	// Control character bounds: C0 below CTRL_C0_END, DEL through C1 below CTRL_C1_END
	localparam cp_t CTRL_C0_END = 21'h00020;
	localparam cp_t CTRL_DEL    = 21'h0007F;
	localparam cp_t CTRL_C1_END = 21'h000A0;
	// Ideographic half fill space sits inside the CJK wide span but is narrow
	localparam cp_t WIDE_HOLE   = 21'h0303F;

	localparam span_t ZW_ROM [ZW_COUNT] = '{
		'{21'h0300,21'h036F}, '{21'h0483,21'h0486}, '{21'h0488,21'h0489},
		'{21'h0591,21'h05BD}, '{21'h05BF,21'h05BF}, '{21'h05C1,21'h05C2},
		'{21'h05C4,21'h05C5}, '{21'h05C7,21'h05C7}, '{21'h0600,21'h0603},
		'{21'h0610,21'h0615}, '{21'h064B,21'h065E}, '{21'h0670,21'h0670},
		'{21'h06D6,21'h06E4}, '{21'h06E7,21'h06E8}, '{21'h06EA,21'h06ED},
		'{21'h070F,21'h070F}, '{21'h0711,21'h0711}, '{21'h0730,21'h074A},
		'{21'h07A6,21'h07B0}, '{21'h07EB,21'h07F3}, '{21'h0901,21'h0902},
		'{21'h093C,21'h093C}, '{21'h0941,21'h0948}, '{21'h094D,21'h094D},
		'{21'h0951,21'h0954}, '{21'h0962,21'h0963}, '{21'h0981,21'h0981},
		'{21'h09BC,21'h09BC}, '{21'h09C1,21'h09C4}, '{21'h09CD,21'h09CD},
		'{21'h09E2,21'h09E3}, '{21'h0A01,21'h0A02}, '{21'h0A3C,21'h0A3C},
		'{21'h0A41,21'h0A42}, '{21'h0A47,21'h0A48}, '{21'h0A4B,21'h0A4D},
		'{21'h0A70,21'h0A71}, '{21'h0A81,21'h0A82}, '{21'h0ABC,21'h0ABC},
		'{21'h0AC1,21'h0AC5}, '{21'h0AC7,21'h0AC8}, '{21'h0ACD,21'h0ACD},
		'{21'h0AE2,21'h0AE3}, '{21'h0B01,21'h0B01}, '{21'h0B3C,21'h0B3C},
		'{21'h0B3F,21'h0B3F}, '{21'h0B41,21'h0B43}, '{21'h0B4D,21'h0B4D},
		'{21'h0B56,21'h0B56}, '{21'h0B82,21'h0B82}, '{21'h0BC0,21'h0BC0},
		'{21'h0BCD,21'h0BCD}, '{21'h0C3E,21'h0C40}, '{21'h0C46,21'h0C48},
		'{21'h0C4A,21'h0C4D}, '{21'h0C55,21'h0C56}, '{21'h0CBC,21'h0CBC},
		'{21'h0CBF,21'h0CBF}, '{21'h0CC6,21'h0CC6}, '{21'h0CCC,21'h0CCD},
		'{21'h0CE2,21'h0CE3}, '{21'h0D41,21'h0D43}, '{21'h0D4D,21'h0D4D},
		'{21'h0DCA,21'h0DCA}, '{21'h0DD2,21'h0DD4}, '{21'h0DD6,21'h0DD6},
		'{21'h0E31,21'h0E31}, '{21'h0E34,21'h0E3A}, '{21'h0E47,21'h0E4E},
		'{21'h0EB1,21'h0EB1}, '{21'h0EB4,21'h0EB9}, '{21'h0EBB,21'h0EBC},
		'{21'h0EC8,21'h0ECD}, '{21'h0F18,21'h0F19}, '{21'h0F35,21'h0F35},
		'{21'h0F37,21'h0F37}, '{21'h0F39,21'h0F39}, '{21'h0F71,21'h0F7E},
		'{21'h0F80,21'h0F84}, '{21'h0F86,21'h0F87}, '{21'h0F90,21'h0F97},
		'{21'h0F99,21'h0FBC}, '{21'h0FC6,21'h0FC6}, '{21'h102D,21'h1030},
		'{21'h1032,21'h1032}, '{21'h1036,21'h1037}, '{21'h1039,21'h1039},
		'{21'h1058,21'h1059}, '{21'h1160,21'h11FF}, '{21'h135F,21'h135F},
		'{21'h1712,21'h1714}, '{21'h1732,21'h1734}, '{21'h1752,21'h1753},
		'{21'h1772,21'h1773}, '{21'h17B4,21'h17B5}, '{21'h17B7,21'h17BD},
		'{21'h17C6,21'h17C6}, '{21'h17C9,21'h17D3}, '{21'h17DD,21'h17DD},
		'{21'h180B,21'h180D}, '{21'h18A9,21'h18A9}, '{21'h1920,21'h1922},
		'{21'h1927,21'h1928}, '{21'h1932,21'h1932}, '{21'h1939,21'h193B},
		'{21'h1A17,21'h1A18}, '{21'h1B00,21'h1B03}, '{21'h1B34,21'h1B34},
		'{21'h1B36,21'h1B3A}, '{21'h1B3C,21'h1B3C}, '{21'h1B42,21'h1B42},
		'{21'h1B6B,21'h1B73}, '{21'h1DC0,21'h1DCA}, '{21'h1DFE,21'h1DFF},
		'{21'h200B,21'h200F}, '{21'h202A,21'h202E}, '{21'h2060,21'h2063},
		'{21'h206A,21'h206F}, '{21'h20D0,21'h20EF}, '{21'h302A,21'h302F},
		'{21'h3099,21'h309A}, '{21'hA806,21'hA806}, '{21'hA80B,21'hA80B},
		'{21'hA825,21'hA826}, '{21'hFB1E,21'hFB1E}, '{21'hFE00,21'hFE0F},
		'{21'hFE20,21'hFE23}, '{21'hFEFF,21'hFEFF}, '{21'hFFF9,21'hFFFB},
		'{21'h10A01,21'h10A03}, '{21'h10A05,21'h10A06}, '{21'h10A0C,21'h10A0F},
		'{21'h10A38,21'h10A3A}, '{21'h10A3F,21'h10A3F}, '{21'h1D167,21'h1D169},
		'{21'h1D173,21'h1D182}, '{21'h1D185,21'h1D18B}, '{21'h1D1AA,21'h1D1AD},
		'{21'h1D242,21'h1D244}, '{21'hE0001,21'hE0001}, '{21'hE0020,21'hE007F},
		'{21'hE0100,21'hE01EF}
	};

	localparam span_t WIDE_ROM [WIDE_COUNT] = '{
		'{21'h01100,21'h0115F}, '{21'h02329,21'h0232A}, '{21'h02E80,21'h0A4CF},
		'{21'h0AC00,21'h0D7A3}, '{21'h0F900,21'h0FAFF}, '{21'h0FE10,21'h0FE19},
		'{21'h0FE30,21'h0FE6F}, '{21'h0FF00,21'h0FF60}, '{21'h0FFE0,21'h0FFE6},
		'{21'h1F300,21'h1F5FF}, '{21'h20000,21'h2FFFD}, '{21'h30000,21'h3FFFD}
	};

endpackage

// ----- rtl/ccw_classify.sv -----
// Combinational column width classifier: control test, zero width and wide interval match.
`timescale 1ns / 1ps

module ccw_classify (
	input  ccw_pkg::cp_t   codepoint,
	output ccw_pkg::cols_t columns
);
	import ccw_pkg::*;

	logic is_null;
	logic is_ctrl;
	logic zw_hit;
	logic wide_hit;

	assign is_null = (codepoint == '0);
	assign is_ctrl = (codepoint < CTRL_C0_END) ||
	                 ((codepoint >= CTRL_DEL) && (codepoint < CTRL_C1_END));

	// Independent range compares against every table entry, OR-reduced
	always_comb begin
		zw_hit = 1'b0;
		for (int k = 0; k < ZW_COUNT; k++) begin
			if ((codepoint >= ZW_ROM[k].lo) && (codepoint <= ZW_ROM[k].hi)) begin
				zw_hit = 1'b1;
			end
		end
	end

	always_comb begin
		wide_hit = 1'b0;
		for (int k = 0; k < WIDE_COUNT; k++) begin
			if ((codepoint >= WIDE_ROM[k].lo) && (codepoint <= WIDE_ROM[k].hi)) begin
				wide_hit = 1'b1;
			end
		end
		if (codepoint == WIDE_HOLE) begin
			wide_hit = 1'b0;
		end
	end

	always_comb begin
		if (is_null) begin
			columns = COLS_ZERO;
		end else if (is_ctrl) begin
			columns = COLS_CTRL;
		end else if (zw_hit) begin
			columns = COLS_ZERO;
		end else if (wide_hit) begin
			columns = COLS_TWO;
		end else begin
			columns = COLS_ONE;
		end
	end

endmodule

// ----- rtl/codepoint_column_width_core.sv -----
// Top level: streaming code point to terminal column width converter.
// Path: the code point is registered in stage 1, classified and registered in stage 2,
// which drives the master side; a master-side stall holds the result in stage 2.
// Throughput: one code point per cycle when not stalled; the rate is set by the single
// classifier pass between the input register and the result register.
// Reset: arst_n clears both stage valid flags asynchronously; payload registers are not reset.
// No clearing pass is needed after reset; the interval tables are constants.
`timescale 1ns / 1ps

module codepoint_column_width_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ccw_pkg::IN_BYTES_W-1:0]     s_tdata,   // [20:0] codepoint, [23:21] zero
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ccw_pkg::OUT_BYTES_W-1:0]    m_tdata    // [2:0] columns (signed), [7:3] zero
);
	import ccw_pkg::*;

	// Stage 1: registered code point
	logic  valid_s1;
	cp_t   cp_s1;
	// Stage 2: registered result, drives the master side
	logic  valid_s2;
	cols_t cols_s2;

	cols_t cols_comb;
	logic  adv_s2;
	logic  adv_s1;

	// Stage 2 takes a new result when empty or when its current one transfers this cycle.
	assign adv_s2 = !valid_s2 || m_tready;
	// Stage 1 takes a new code point when empty or when its contents move on into stage 2,
	// so a waiting result never blocks the next input transfer by more than one slot.
	assign adv_s1 = !valid_s1 || adv_s2;

	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the code point while stalled; load on every free slot.
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			cp_s1 <= s_tdata[CP_W-1:0];
		end
	end

	ccw_classify u_classify (
		.codepoint (cp_s1),
		.columns   (cols_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Advance the result only when stage 2 is free; hold it otherwise.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			cols_s2 <= cols_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_BYTES_W-COLS_W){1'b0}}, cols_s2};

endmodule

// ----- rtl/ccw_checker.sv -----
// Port-level assertions for the column width core and the bind that attaches them.
`timescale 1ns / 1ps

module ccw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ccw_pkg::IN_BYTES_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ccw_pkg::OUT_BYTES_W-1:0] m_tdata
);
	import ccw_pkg::*;

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input side backs up only when both stages are full and the output stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	// Results are only 0, 1, 2 or -1 with zero padding.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:3] == 5'd0) && (m_tdata[2:0] != 3'd3) &&
		(m_tdata[2:0] != 3'd4) && (m_tdata[2:0] != 3'd5) && (m_tdata[2:0] != 3'd6))
		else $error("result out of range");

	// A null code point that flows through without stall comes out zero wide.
	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && $past(arst_n) && $past(arst_n, 2) && $past(m_tready) &&
		$past(s_tvalid && s_tready, 2) && ($past(s_tdata[20:0], 2) == 21'd0)
		|-> m_tdata[2:0] == 3'd0)
		else $error("null code point not zero width");

endmodule

bind codepoint_column_width_core ccw_checker u_ccw_checker (.*);
